[rtl/tccw_pkg.sv]
`timescale 1ns / 1ps

package tccw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] BLANK_CODE   = 8'd32;
  localparam logic [7:0] ATTR_RESET   = 8'd240;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_SET   = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

endpackage

[rtl/tccw_if.sv]
`timescale 1ns / 1ps

interface tccw_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] char_code;
  logic [6:0] pos_column;
  logic [4:0] pos_row;

  modport source (output valid, cmd, char_code, pos_column, pos_row, input ready);
  modport sink   (input valid, cmd, char_code, pos_column, pos_row, output ready);
endinterface

interface tccw_rsp_if;
  logic        valid;
  logic        ready;
  logic [6:0]  cursor_column;
  logic [4:0]  cursor_row;
  logic [10:0] cursor_offset;
  logic [15:0] cell_entry;
  logic        did_scroll;

  modport source (output valid, cursor_column, cursor_row, cursor_offset, cell_entry,
                  did_scroll, input ready);
  modport sink   (input valid, cursor_column, cursor_row, cursor_offset, cell_entry,
                  did_scroll, output ready);
endinterface

[rtl/tccw_ram.sv]
`timescale 1ns / 1ps

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/text_console_char_writer.sv]
`timescale 1ns / 1ps

// Text console engine: a COLUMNS x ROWS screen of 16-bit cells (attribute
// high byte, character low byte) in a single-port-write, registered-read
// RAM, plus a cursor. Commands: put character (newline code wraps), clear,
// set cursor position (saturated to the screen), read cell. Each command
// returns one word with the cursor, its linear offset and the read cell.
// Clear makes one RAM write per cell. A put that runs past the last row
// scrolls the screen: one cell is copied up per cycle through the RAM's
// read and write ports, then the bottom row is blanked. The block takes
// no new command while one is in progress; a finished response may wait
// in its output register.
// Cells must be written (by clear) before they are read.
module text_console_char_writer
  import tccw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  tccw_req_if.sink   req,
  tccw_rsp_if.source rsp
);

  localparam int CELLS    = COLUMNS * ROWS;
  localparam int AW       = $clog2(CELLS);
  localparam int CW       = $clog2(COLUMNS);
  localparam int RW       = $clog2(ROWS);
  localparam int LAST_ROW = CELLS - COLUMNS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CALC   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_RDWAIT = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;
  localparam logic [2:0] ST_FLUSH  = 3'd5;
  localparam logic [2:0] ST_BLANK  = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;

  logic [2:0]    state;
  logic [7:0]    attr;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [AW-1:0] ptr;
  logic          pend;
  logic [AW-1:0] pend_addr;

  logic [1:0]    cmd_r;
  logic [7:0]    ch_r;
  logic [6:0]    pcol_r;
  logic [4:0]    prow_r;
  logic [AW-1:0] addr;
  logic          rd_ok;
  logic [15:0]   rd_word;
  logic          scrolled;

  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [AW-1:0] raddr;
  logic [15:0]   rdata;

  logic [RW-1:0] mul_row;
  logic [CW-1:0] mul_col;
  logic [AW-1:0] mul_out;
  logic          col_in;
  logic          row_in;
  logic          is_nl;
  logic          last_col;
  logic          last_row;
  logic          rsp_free;

  assign col_in   = 32'(pcol_r) < COLUMNS;
  assign row_in   = 32'(prow_r) < ROWS;
  assign is_nl    = ch_r == NEWLINE_CODE;
  assign last_col = cur_col == CW'(COLUMNS - 1);
  assign last_row = cur_row == RW'(ROWS - 1);
  assign rsp_free = !rsp.valid || rsp.ready;

  // shared offset unit: row * COLUMNS + column
  always_comb begin
    if (state == ST_CALC && cmd_r == CMD_READ) begin
      mul_row = RW'(prow_r);
      mul_col = CW'(pcol_r);
    end else begin
      mul_row = cur_row;
      mul_col = cur_col;
    end
    mul_out = AW'(AW'(mul_row) * AW'(COLUMNS)) + AW'(mul_col);
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = {attr, ch_r};
    raddr = addr;
    unique case (state)
      ST_EXEC: begin
        we = (cmd_r == CMD_PUT) && !is_nl;
      end
      ST_SCROLL: begin
        raddr = ptr + AW'(COLUMNS);
        we    = pend;
        waddr = pend_addr;
        wdata = rdata;
      end
      ST_FLUSH: begin
        we    = 1'b1;
        waddr = pend_addr;
        wdata = rdata;
      end
      ST_BLANK: begin
        we    = 1'b1;
        waddr = ptr;
        wdata = {attr, BLANK_CODE};
      end
      default: begin
      end
    endcase
  end

  tccw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign req.ready = state == ST_IDLE;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      attr      <= ATTR_RESET;
      cur_col   <= '0;
      cur_row   <= '0;
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr <= cfg_wdata;
      end
      if (state == ST_FIN && rsp_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          unique case (cmd_r)
            CMD_PUT: begin
              if (is_nl || last_col) begin
                cur_col <= '0;
                if (last_row) begin
                  pend  <= 1'b0;
                  state <= ST_SCROLL;
                end else begin
                  cur_row <= cur_row + RW'(1);
                  state   <= ST_FIN;
                end
              end else begin
                cur_col <= cur_col + CW'(1);
                state   <= ST_FIN;
              end
            end
            CMD_CLEAR: begin
              cur_col <= '0;
              cur_row <= '0;
              state   <= ST_BLANK;
            end
            CMD_SET: begin
              cur_col <= col_in ? CW'(pcol_r) : CW'(COLUMNS - 1);
              cur_row <= row_in ? RW'(prow_r) : RW'(ROWS - 1);
              state   <= ST_FIN;
            end
            default: begin
              state <= rd_ok ? ST_RDWAIT : ST_FIN;
            end
          endcase
        end
        ST_RDWAIT: begin
          state <= ST_FIN;
        end
        ST_SCROLL: begin
          pend <= 1'b1;
          if (ptr == AW'(LAST_ROW - 1)) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          pend  <= 1'b0;
          state <= ST_BLANK;
        end
        ST_BLANK: begin
          if (ptr == AW'(CELLS - 1)) begin
            state <= ST_FIN;
          end
        end
        default: begin
          if (rsp_free) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cmd_r    <= req.cmd;
        ch_r     <= req.char_code;
        pcol_r   <= req.pos_column;
        prow_r   <= req.pos_row;
        rd_word  <= '0;
        scrolled <= 1'b0;
      end
      ST_CALC: begin
        addr  <= mul_out;
        rd_ok <= col_in && row_in;
        ptr   <= '0;
      end
      ST_EXEC: begin
        if (cmd_r == CMD_PUT && (is_nl || last_col) && last_row) begin
          scrolled <= 1'b1;
        end
      end
      ST_RDWAIT: begin
        rd_word <= rdata;
      end
      ST_SCROLL: begin
        pend_addr <= ptr;
        ptr       <= ptr + AW'(1);
      end
      ST_FLUSH: begin
        ptr <= AW'(LAST_ROW);
      end
      ST_BLANK: begin
        ptr <= ptr + AW'(1);
      end
      default: begin
        if (rsp_free) begin
          rsp.cursor_column <= 7'(cur_col);
          rsp.cursor_row    <= 5'(cur_row);
          rsp.cursor_offset <= 11'(mul_out);
          rsp.cell_entry    <= rd_word;
          rsp.did_scroll    <= scrolled;
        end
      end
    endcase
  end

endmodule
